// ===== src/sdrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrt_pkg
// Shared types and constants for the sorted date reminder table.
// ----------------------------------------------------------------------------
package sdrt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TAG_WIDTH   = 16;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W   = 9;
    localparam int ENTRY_W = KEY_W + TAG_WIDTH;

    // Stream field widths
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int IN_TAG_W  = 16;
    localparam int IDX_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_TAG_W = 16;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;
    localparam int CMP_W     = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_DATE  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_SCAN,
        S_PLACE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [TAG_WIDTH-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [POS_W-1:0]     pos;
        logic [OUT_TAG_W-1:0] tag;
        logic [KEY_W-1:0]     key;
        t_status              status;
    } t_result;

    // Days in all whole months before the given month (non-leap year).
    function automatic logic [KEY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [KEY_W-1:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/sorted_date_reminder_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_date_reminder_table_core
// Reminder table kept sorted by day of year, with insert and indexed read.
// ----------------------------------------------------------------------------
// An insert request converts month/day to a non-leap day of year and places
// the entry after every stored entry with an equal or smaller key, so equal
// dates keep arrival order. The table lives in one RAM (key and tag side by
// side). An insert walks the table from the top entry downward, one entry
// per cycle: each entry with a larger key is copied one place up, and the
// walk stops at the first entry whose key is not larger, or after the bottom
// entry. One RAM read per cycle sets the pace of the walk; a full table
// refuses inserts. A read request passes through a RAM read state to the
// result; a refused request (table full, invalid date, index not below
// count) goes straight to the result state. One request is worked on at a
// time; the input is ready whenever the block is idle, even while the
// previous result still waits in the output register. Month must be 1..12
// and day 1..31; a day past its month's end is accepted as the plain sum.
// There is no clearing pass after reset: only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module sorted_date_reminder_table_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side: tdata = month[3:0], day_of_month[8:4], tag[24:9],
    //             index[30:25], zero pad[31]; tuser = op
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sdrt_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    // master side: tdata = status[1:0], entry_key[10:2], entry_tag[26:11],
    //              entry_position[32:27], count[39:33]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sdrt_pkg::M_DATA_W-1:0]       m_tdata
);

    // Field decode
    logic [sdrt_pkg::MONTH_W-1:0]   in_month;
    logic [sdrt_pkg::DAY_W-1:0]     in_day;
    logic [sdrt_pkg::IN_TAG_W-1:0]  in_tag;
    logic [sdrt_pkg::IDX_W-1:0]     in_index;
    sdrt_pkg::t_op                  in_op;

    assign in_month = s_tdata[3:0];
    assign in_day   = s_tdata[8:4];
    assign in_tag   = s_tdata[24:9];
    assign in_index = s_tdata[30:25];
    assign in_op    = sdrt_pkg::t_op'(s_tuser);

    // Registers
    sdrt_pkg::t_state                 r_state, n_state;
    logic [sdrt_pkg::CNT_W-1:0]       r_count, n_count;
    logic [sdrt_pkg::KEY_W-1:0]       r_key, n_key;
    logic [sdrt_pkg::TAG_WIDTH-1:0]   r_tag, n_tag;
    logic [sdrt_pkg::ADDR_W-1:0]      r_ptr, n_ptr;
    sdrt_pkg::t_result                r_res, n_res;
    sdrt_pkg::t_result                r_out, n_out;
    logic                             r_out_valid, n_out_valid;

    // RAM port
    logic                             ram_we;
    logic [sdrt_pkg::ADDR_W-1:0]      ram_waddr;
    sdrt_pkg::t_entry                 ram_wdata;
    logic [sdrt_pkg::ADDR_W-1:0]      ram_raddr;
    sdrt_pkg::t_entry                 ram_rdata;

    // Request checks
    logic                             s_accept;
    logic                             out_free;
    logic                             tbl_full;
    logic                             date_ok;
    logic                             idx_bad;
    logic                             tbl_empty;
    logic                             scan_shift;
    logic                             ptr_zero;
    logic [sdrt_pkg::KEY_W-1:0]       in_key;
    logic [sdrt_pkg::ADDR_W-1:0]      top_addr;
    logic [sdrt_pkg::ADDR_W-1:0]      idx_addr;
    logic [sdrt_pkg::ADDR_W-1:0]      ptr_up;
    logic [sdrt_pkg::CNT_W-1:0]       count_inc;

    assign s_tready   = (r_state == sdrt_pkg::S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !r_out_valid || m_tready;
    assign tbl_full   = (r_count >= sdrt_pkg::CNT_W'(sdrt_pkg::TABLE_DEPTH));
    assign date_ok    = (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day != '0);
    assign idx_bad    = (sdrt_pkg::CMP_W'(in_index) >= sdrt_pkg::CMP_W'(r_count));
    assign tbl_empty  = (r_count == '0);
    assign in_key     = sdrt_pkg::days_before(in_month) + sdrt_pkg::KEY_W'(in_day);
    assign top_addr   = sdrt_pkg::ADDR_W'(r_count - 1'b1);
    assign idx_addr   = sdrt_pkg::ADDR_W'(in_index);
    assign ptr_up     = r_ptr + 1'b1;
    assign ptr_zero   = (r_ptr == '0);
    assign count_inc  = r_count + 1'b1;
    // entry under the walk sorts after the new one: move it up
    assign scan_shift = (ram_rdata.key > r_key);

    sdrt_ram #(
        .WIDTH (sdrt_pkg::ENTRY_W),
        .DEPTH (sdrt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdrt_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (in_op == sdrt_pkg::OP_READ) begin
                        n_state = idx_bad ? sdrt_pkg::S_EMIT : sdrt_pkg::S_RDATA;
                    end else if (tbl_full || !date_ok || tbl_empty) begin
                        n_state = sdrt_pkg::S_EMIT;
                    end else begin
                        n_state = sdrt_pkg::S_SCAN;
                    end
                end
            end
            sdrt_pkg::S_RDATA: n_state = sdrt_pkg::S_EMIT;
            sdrt_pkg::S_SCAN: begin
                if (!scan_shift) begin
                    n_state = sdrt_pkg::S_EMIT;
                end else if (ptr_zero) begin
                    n_state = sdrt_pkg::S_PLACE;
                end
            end
            sdrt_pkg::S_PLACE: n_state = sdrt_pkg::S_EMIT;
            sdrt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = sdrt_pkg::S_IDLE;
                end
            end
            default: n_state = sdrt_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_count     = r_count;
        n_key       = r_key;
        n_tag       = r_tag;
        n_ptr       = r_ptr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = ptr_up;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_ptr - 1'b1;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sdrt_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_key = in_key;
                    n_tag = sdrt_pkg::TAG_WIDTH'(in_tag);
                    if (in_op == sdrt_pkg::OP_READ) begin
                        ram_raddr = idx_addr;
                        n_ptr     = idx_addr;
                        n_res     = '{count: sdrt_pkg::COUNT_W'(r_count), pos: '0,
                                      tag: '0, key: '0, status: sdrt_pkg::ST_BAD_INDEX};
                    end else if (tbl_full) begin
                        n_res = '{count: sdrt_pkg::COUNT_W'(r_count), pos: '0,
                                  tag: '0, key: '0, status: sdrt_pkg::ST_FULL};
                    end else if (!date_ok) begin
                        n_res = '{count: sdrt_pkg::COUNT_W'(r_count), pos: '0,
                                  tag: '0, key: '0, status: sdrt_pkg::ST_BAD_DATE};
                    end else if (tbl_empty) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = '{key: in_key, tag: sdrt_pkg::TAG_WIDTH'(in_tag)};
                        n_count   = count_inc;
                        n_res     = '{count: sdrt_pkg::COUNT_W'(count_inc), pos: '0,
                                      tag: sdrt_pkg::OUT_TAG_W'(
                                          sdrt_pkg::TAG_WIDTH'(in_tag)),
                                      key: in_key, status: sdrt_pkg::ST_OK};
                    end else begin
                        // start the walk at the top entry
                        ram_raddr = top_addr;
                        n_ptr     = top_addr;
                    end
                end
            end
            sdrt_pkg::S_RDATA: begin
                n_res = '{count: sdrt_pkg::COUNT_W'(r_count),
                          pos: sdrt_pkg::POS_W'(r_ptr),
                          tag: sdrt_pkg::OUT_TAG_W'(ram_rdata.tag),
                          key: ram_rdata.key, status: sdrt_pkg::ST_OK};
            end
            sdrt_pkg::S_SCAN: begin
                // writes land above every address still to be read
                ram_we    = 1'b1;
                ram_waddr = ptr_up;
                if (scan_shift) begin
                    ram_wdata = ram_rdata;
                    n_ptr     = ptr_zero ? r_ptr : r_ptr - 1'b1;
                end else begin
                    ram_wdata = '{key: r_key, tag: r_tag};
                    n_count   = count_inc;
                    n_res     = '{count: sdrt_pkg::COUNT_W'(count_inc),
                                  pos: sdrt_pkg::POS_W'(ptr_up),
                                  tag: sdrt_pkg::OUT_TAG_W'(r_tag),
                                  key: r_key, status: sdrt_pkg::ST_OK};
                end
            end
            sdrt_pkg::S_PLACE: begin
                // every stored key was larger: new entry goes to the bottom
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{key: r_key, tag: r_tag};
                n_count   = count_inc;
                n_res     = '{count: sdrt_pkg::COUNT_W'(count_inc), pos: '0,
                              tag: sdrt_pkg::OUT_TAG_W'(r_tag),
                              key: r_key, status: sdrt_pkg::ST_OK};
            end
            sdrt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdrt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
        r_ptr <= n_ptr;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sdrt_pkg::CNT_W'(sdrt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + 1'b1))
        else $error("entry count changed by other than one");

    a_no_write_idle_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state != sdrt_pkg::S_RDATA) && (r_state != sdrt_pkg::S_EMIT)))
        else $error("table write outside insert states");

    a_walk_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdrt_pkg::S_SCAN) |-> (sdrt_pkg::CNT_W'(r_ptr) < r_count))
        else $error("insert walk beyond stored entries");

endmodule

// ===== src/sdrt_ram.sv =====
// ----------------------------------------------------------------------------
// sdrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
